[src/tga_rle_pixel_decoder_defines.svh]
// Assertion macros for the TGA RLE pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TGARLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TGARLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tgarle_pkg.sv]
// Shared types and constants for the TGA RLE pixel decoder.
package tgarle_pkg;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 3;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_RUN_LENGTH_CODED  = 2'd0,
        CFG_PIXEL_BYTES       = 2'd1,
        CFG_SIXTEEN_BIT_ALPHA = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       run_length_coded;
        logic [2:0] pixel_bytes;
        logic       sixteen_bit_alpha;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
    } pixel_t;

endpackage

[src/tgarle_decode.sv]
// Packet and pixel state, byte assembly and colour conversion.
module tgarle_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  tgarle_pkg::cfg_t  cfg,
    input  logic              beat_valid,
    input  logic [7:0]        data_byte,
    input  logic              image_start,
    output logic              pix_valid,
    output tgarle_pkg::pixel_t pix
);

    logic [7:0]  rem_reg,  rem_next;
    logic        run_reg,  run_next;
    logic [23:0] asm_reg,  asm_next;
    logic [1:0]  bip_reg,  bip_next;

    logic [7:0]  rem_cur;
    logic        run_cur;
    logic [23:0] asm_cur;
    logic [1:0]  bip_cur;
    logic [2:0]  size;
    logic [2:0]  bip_inc;
    logic        is_header;
    logic        is_assemble;
    logic        is_complete;
    logic [7:0]  b0, b1, b2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            run_reg <= 1'b0;
            asm_reg <= '0;
            bip_reg <= '0;
        end else if (beat_valid) begin
            rem_reg <= rem_next;
            run_reg <= run_next;
            asm_reg <= asm_next;
            bip_reg <= bip_next;
        end
    end

    always_comb begin
        // image_start wipes the stream state before the byte is used
        rem_cur = image_start ? 8'd0  : rem_reg;
        run_cur = image_start ? 1'b0  : run_reg;
        asm_cur = image_start ? 24'd0 : asm_reg;
        bip_cur = image_start ? 2'd0  : bip_reg;

        if (cfg.pixel_bytes < 3'd2) begin
            size = 3'd2;
        end else if (cfg.pixel_bytes > 3'd4) begin
            size = 3'd4;
        end else begin
            size = cfg.pixel_bytes;
        end

        bip_inc     = {1'b0, bip_cur} + 3'd1;
        is_header   = cfg.run_length_coded && (rem_cur == 8'd0);
        is_assemble = !is_header && (bip_inc < size);
        is_complete = !is_header && !is_assemble;

        b0 = asm_cur[7:0];
        b1 = asm_cur[15:8];
        b2 = asm_cur[23:16];

        rem_next = rem_cur;
        run_next = run_cur;
        asm_next = asm_cur;
        bip_next = bip_cur;

        if (is_header) begin
            rem_next = {1'b0, data_byte[6:0]} + 8'd1;
            run_next = data_byte[7];
            asm_next = '0;
            bip_next = '0;
        end else if (is_assemble) begin
            unique case (bip_cur)
                2'd0: asm_next[7:0]   = data_byte;
                2'd1: asm_next[15:8]  = data_byte;
                2'd2: asm_next[23:16] = data_byte;
                2'd3: asm_next        = asm_cur;
            endcase
            bip_next = bip_inc[1:0];
        end else begin
            asm_next = '0;
            bip_next = '0;
            if (cfg.run_length_coded) begin
                rem_next = run_cur ? 8'd0 : rem_cur - 8'd1;
            end
        end

        // colour conversion; data_byte is the closing byte of the pixel
        unique case (size)
            3'd2: begin
                pix.red   = {data_byte[6:2], 3'b000};
                pix.green = {data_byte[1:0], b0[7:5], 3'b000};
                pix.blue  = {b0[4:0], 3'b000};
                pix.alpha = (cfg.sixteen_bit_alpha && data_byte[7]) ? 8'hff : 8'h00;
            end
            3'd3: begin
                pix.red   = data_byte;
                pix.green = b1;
                pix.blue  = b0;
                pix.alpha = 8'h00;
            end
            default: begin
                pix.red   = b2;
                pix.green = b1;
                pix.blue  = b0;
                pix.alpha = data_byte;
            end
        endcase

        pix.repeat_count = (cfg.run_length_coded && run_cur) ? rem_cur : 8'd1;
        pix_valid        = beat_valid && is_complete;
    end

endmodule

[src/tgarle_out_reg.sv]
// Result register that holds a decoded pixel until the sink takes it.
module tgarle_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  tgarle_pkg::pixel_t pix,
    output logic               can_accept,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata
);

    logic               valid_reg, valid_next;
    tgarle_pkg::pixel_t pix_reg;

    always_comb begin
        can_accept = !valid_reg || m_tready;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg <= pix;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {pix_reg.repeat_count, pix_reg.alpha, pix_reg.blue,
                       pix_reg.green, pix_reg.red};

endmodule

[src/tga_rle_pixel_decoder.sv]
// TGA truecolor pixel-data decoder: one RGBA pixel out per pixel, one byte in per cycle
// while s_tready is high. A decoded pixel appears on the result channel the cycle after
// its closing byte is accepted, from a single output register. s_tready falls only
// while that register holds a pixel the sink has not taken, so throughput is one byte
// per cycle whenever m_tready stays high. Header and non-final pixel bytes produce no
// beat. Configuration is written through cfg_wr_en, cfg_index and cfg_wdata, and must
// only change while the decoder is idle.
`include "tga_rle_pixel_decoder_defines.svh"

module tga_rle_pixel_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_tuser,    // [0] image_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [39:32] repeat_count
);

    tgarle_pkg::cfg_t   cfg_reg;
    tgarle_pkg::pixel_t pix;
    logic               beat_valid;
    logic               pix_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_length_coded  <= 1'b0;
            cfg_reg.pixel_bytes       <= 3'd3;
            cfg_reg.sixteen_bit_alpha <= 1'b0;
        end else if (cfg_wr_en) begin
            if (cfg_index == tgarle_pkg::CFG_RUN_LENGTH_CODED) begin
                cfg_reg.run_length_coded <= cfg_wdata[0];
            end
            if (cfg_index == tgarle_pkg::CFG_PIXEL_BYTES) begin
                cfg_reg.pixel_bytes <= cfg_wdata;
            end
            if (cfg_index == tgarle_pkg::CFG_SIXTEEN_BIT_ALPHA) begin
                cfg_reg.sixteen_bit_alpha <= cfg_wdata[0];
            end
        end
    end

    assign beat_valid = s_tvalid && s_tready;

    tgarle_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .beat_valid  (beat_valid),
        .data_byte   (s_tdata),
        .image_start (s_tuser[0]),
        .pix_valid   (pix_valid),
        .pix         (pix)
    );

    tgarle_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (pix_valid),
        .pix        (pix),
        .can_accept (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    `TGARLE_ASSERT_NOW(a_count_nonzero, m_tvalid, m_tdata[39:32] != 8'd0, "zero repeat count")
    `TGARLE_ASSERT_NOW(a_raw_count_one, m_tvalid && !cfg_reg.run_length_coded,
                       m_tdata[39:32] == 8'd1, "raw pixel with repeat count above one")
    `TGARLE_ASSERT_NOW(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready,
                       "input stalled with room in the result register")
    `TGARLE_ASSERT_NEXT(a_pixel_shown, pix_valid, m_tvalid, "decoded pixel not presented")

endmodule

[verif/tga_rle_pixel_checker.sv]
// Pixel checker for the TGA RLE decoder: tracks configuration, predicts and compares pixels.
`timescale 1ns / 1ps

module tga_rle_pixel_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  tgarle_pkg::cfg_index_t cfg_index,
    input  logic [2:0]             cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] data_byte
    input  logic [0:0]             s_tuser,    // [0] image_start
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [39:0]            m_tdata,    // [7:0] red, [15:8] green, [23:16] blue,
                                               // [31:24] alpha, [39:32] repeat_count
    output int                     error_count,
    output int                     pixels_outstanding
);

    tgarle_pkg::cfg_t   cfg;
    logic [7:0]         packet_left;
    logic               in_run_packet;
    logic [23:0]        assembly;
    logic [1:0]         bytes_seen;
    tgarle_pkg::pixel_t expected_pixels[$];
    int                 mismatches = 0;

    assign error_count = mismatches;

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic decode_byte(input logic [7:0] data, input logic image_start);
        int                 size;
        tgarle_pkg::pixel_t px;
        size = (cfg.pixel_bytes < 3'd2) ? 2 : (cfg.pixel_bytes > 3'd4) ? 4 : int'(cfg.pixel_bytes);
        if (image_start) begin
            packet_left   = '0;
            in_run_packet = 1'b0;
            assembly      = '0;
            bytes_seen    = '0;
        end
        // a byte arriving with no packet open is a header
        if (cfg.run_length_coded && packet_left == 8'd0) begin
            packet_left   = {1'b0, data[6:0]} + 8'd1;
            in_run_packet = data[7];
            bytes_seen    = '0;
            assembly      = '0;
            return;
        end
        if (int'(bytes_seen) + 1 < size) begin
            assembly[8*bytes_seen +: 8] = data;
            bytes_seen = bytes_seen + 2'd1;
            return;
        end
        case (size)
            2: begin
                px.red   = {data[6:2], 3'b000};
                px.green = {data[1:0], assembly[7:5], 3'b000};
                px.blue  = {assembly[4:0], 3'b000};
                px.alpha = (cfg.sixteen_bit_alpha && data[7]) ? 8'hff : 8'h00;
            end
            3: begin
                px.red   = data;
                px.green = assembly[15:8];
                px.blue  = assembly[7:0];
                px.alpha = 8'h00;
            end
            default: begin
                px.red   = assembly[23:16];
                px.green = assembly[15:8];
                px.blue  = assembly[7:0];
                px.alpha = data;
            end
        endcase
        px.repeat_count = 8'd1;
        bytes_seen = '0;
        assembly   = '0;
        if (cfg.run_length_coded) begin
            if (in_run_packet) begin
                px.repeat_count = packet_left;
                packet_left     = '0;
            end else begin
                packet_left = packet_left - 8'd1;
            end
        end
        expected_pixels.push_back(px);
    endtask

    always @(posedge aclk) begin
        tgarle_pkg::pixel_t want;
        if (!aresetn) begin
            cfg = '{run_length_coded: 1'b0, pixel_bytes: 3'd3, sixteen_bit_alpha: 1'b0};
            packet_left   = '0;
            in_run_packet = 1'b0;
            assembly      = '0;
            bytes_seen    = '0;
            expected_pixels.delete();
        end else begin
            // a pixel beat always belongs to a byte taken at an earlier edge
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel beat: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red",          want.red,          m_tdata[7:0]);
                    check_field("green",        want.green,        m_tdata[15:8]);
                    check_field("blue",         want.blue,         m_tdata[23:16]);
                    check_field("alpha",        want.alpha,        m_tdata[31:24]);
                    check_field("repeat_count", want.repeat_count, m_tdata[39:32]);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    tgarle_pkg::CFG_RUN_LENGTH_CODED:  cfg.run_length_coded  = cfg_wdata[0];
                    tgarle_pkg::CFG_PIXEL_BYTES:       cfg.pixel_bytes       = cfg_wdata;
                    tgarle_pkg::CFG_SIXTEEN_BIT_ALPHA: cfg.sixteen_bit_alpha = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0]);
        end
        pixels_outstanding <= expected_pixels.size();
    end

endmodule

[verif/tb_tga_rle_pixel_decoder.sv]
// Testbench top for the TGA RLE pixel decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;

    localparam int CycleLimit = 400000;

    logic                   aclk       = 1'b0;
    logic                   aresetn    = 1'b0;
    logic                   cfg_wr_en  = 1'b0;
    tgarle_pkg::cfg_index_t cfg_index  = tgarle_pkg::CFG_RUN_LENGTH_CODED;
    logic [2:0]             cfg_wdata  = '0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata    = '0;
    logic [0:0]             s_tuser    = '0;
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [39:0]            m_tdata;
    int                     error_count;
    int                     pixels_outstanding;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          cycle_count    = 0;
    logic        cur_rle  = 1'b0;
    logic [2:0]  cur_size = 3'd3;

    tga_rle_pixel_decoder dut (.*);

    tga_rle_pixel_checker checker_i (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("tb_tga_rle_pixel_decoder: errors");
            $finish;
        end
    end

    function automatic int eff_size(logic [2:0] pb);
        return (pb < 3'd2) ? 2 : (pb > 3'd4) ? 4 : int'(pb);
    endfunction

    task automatic send_byte(input logic image_start, input logic [7:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= image_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drop valid, let every pixel drain, then allow for a trailing header or partial pixel
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pixels_outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic rle, input logic [2:0] size, input logic alpha);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= tgarle_pkg::CFG_RUN_LENGTH_CODED;
        cfg_wdata <= {2'b00, rle};
        @(posedge aclk);
        cfg_index <= tgarle_pkg::CFG_PIXEL_BYTES;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_index <= tgarle_pkg::CFG_SIXTEEN_BIT_ALPHA;
        cfg_wdata <= {2'b00, alpha};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_rle  = rle;
        cur_size = size;
    endtask

    // well-formed packets (run-length mode) or raw bytes of random content, with stray bytes mixed in
    task automatic send_segment(input int budget);
        int         sent;
        int         size;
        int         pixels;
        logic       first_start;
        logic [7:0] hdr;
        sent        = 0;
        size        = eff_size(cur_size);
        first_start = ($urandom_range(0, 9) < 7);
        while (sent < budget) begin
            if ($urandom_range(0, 24) == 0) begin
                send_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
                sent++;
            end else if (cur_rle) begin
                hdr[7] = 1'($urandom_range(0, 1));
                if (hdr[7])
                    hdr[6:0] = 7'($urandom_range(0, 127));
                else if ($urandom_range(0, 39) == 0)
                    hdr[6:0] = 7'd127;
                else
                    hdr[6:0] = 7'($urandom_range(0, 3));
                send_byte(first_start && sent == 0, hdr);
                sent++;
                pixels = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
                repeat (pixels * size) begin
                    send_byte(1'b0, 8'($urandom_range(0, 255)));
                    sent++;
                end
            end else begin
                send_byte((first_start && sent == 0) || $urandom_range(0, 32) == 0,
                          8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        logic [2:0] pb;
        idle_by_phase  = '{0, 48, 0, 17};
        stall_by_phase = '{0, 0, 48, 17};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: raw, three bytes per pixel
        send_byte(1'b1, 8'h12); send_byte(1'b0, 8'h34); send_byte(1'b0, 8'h56);
        set_config(1'b0, 3'd4, 1'b0);
        send_byte(1'b1, 8'h00); send_byte(1'b0, 8'hff); send_byte(1'b0, 8'h80);
        send_byte(1'b0, 8'h7f);
        set_config(1'b0, 3'd2, 1'b1);
        send_byte(1'b1, 8'hff); send_byte(1'b0, 8'hff);
        send_byte(1'b0, 8'he0); send_byte(1'b0, 8'h03);
        set_config(1'b0, 3'd2, 1'b0);
        send_byte(1'b1, 8'hff); send_byte(1'b0, 8'hff);
        // longest run packet, then a one-pixel raw packet
        set_config(1'b1, 3'd3, 1'b0);
        send_byte(1'b1, 8'hff); send_byte(1'b0, 8'h01); send_byte(1'b0, 8'h02);
        send_byte(1'b0, 8'h03);
        send_byte(1'b0, 8'h00); send_byte(1'b0, 8'hfe); send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hff);
        // shrink the pixel size with three bytes already held
        set_config(1'b0, 3'd4, 1'b0);
        send_byte(1'b1, 8'haa); send_byte(1'b0, 8'hbb); send_byte(1'b0, 8'hcc);
        set_config(1'b0, 3'd0, 1'b0);
        send_byte(1'b0, 8'hdd);
        // oversized setting, and an image start landing mid-pixel
        set_config(1'b0, 3'd7, 1'b1);
        send_byte(1'b0, 8'h11); send_byte(1'b1, 8'h22); send_byte(1'b0, 8'h33);
        send_byte(1'b0, 8'h44); send_byte(1'b0, 8'h55);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = idle_by_phase[p];
            sink_stall_pct = stall_by_phase[p];
            repeat (6) begin
                pb = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(2, 4))
                                                 : 3'($urandom_range(0, 7));
                set_config(1'($urandom_range(0, 1)), pb, 1'($urandom_range(0, 1)));
                send_segment(30);
            end
        end

        wait_drained();
        if (error_count == 0 && pixels_outstanding == 0)
            $display("tb_tga_rle_pixel_decoder: clean");
        else
            $display("tb_tga_rle_pixel_decoder: errors");
        $finish;
    end

endmodule
